@@ sv/dtb_pkg.sv @@
// ============================================================================
// dtb_pkg
// Shared types and codes of the dual token bucket throttle.
// ============================================================================
package dtb_pkg;

    localparam int LEN_W     = 32;
    localparam int HOUR_W    = 5;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_IN_W  = 10;
    localparam int KIB_SHIFT = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DREQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DCONS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UREQ  = 2'd3;

    localparam logic [STAT_W-1:0] ST_PASS  = 2'd0;
    localparam logic [STAT_W-1:0] ST_GRANT = 2'd1;
    localparam logic [STAT_W-1:0] ST_WAIT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_MAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_MAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_ALT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_ALT    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_GRANT,
        S_WB
    } t_dtb_state;

    typedef enum logic [2:0] {
        P_TICK,
        P_CONS,
        P_PASS,
        P_WAIT,
        P_GRANT
    } t_dtb_path;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic grant;
        logic write;
    } t_dtb_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dtb_stat;

endpackage

@@ sv/dual_token_bucket_throttle.sv @@
// ============================================================================
// dual_token_bucket_throttle
// Download and upload token buckets with hour-window limit selection.
// ============================================================================
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   in      | i_in_valid / o_in_stall | i_cmd, i_hour, i_request_len,
//           |                         | i_active_count
//   out     | o_out_valid/i_out_stall | o_status, o_grant_len
//   cfg     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Tick, consume, pass and wait items go through accept, evaluate and write
// back. Granted requests add a divide and a grant step, in which the restoring
// divider computes the per-transfer slice one quotient bit per cycle. A new item
// is taken only once the previous one has been written back.
// Synchronous reset empties both buckets, clears the throttle flag and the
// configuration registers; no clearing pass.
// The result register holds while stalled; the next item is taken meanwhile
// and its write back waits until the result register frees up.
// ============================================================================
module dual_token_bucket_throttle #(
    parameter int LIMIT_BITS = 20,
    parameter int COUNT_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_BITS-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dtb_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dtb_pkg::HOUR_W-1:0]    i_hour,
    input  logic [dtb_pkg::LEN_W-1:0]     i_request_len,
    input  logic [dtb_pkg::CNT_IN_W-1:0]  i_active_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dtb_pkg::STAT_W-1:0]    o_status,
    output logic [dtb_pkg::LEN_W-1:0]     o_grant_len
);

    import dtb_pkg::*;

    localparam int CNT_W = (COUNT_BITS < CNT_IN_W) ? COUNT_BITS : CNT_IN_W;

    t_dtb_cmd  w_ctl;
    t_dtb_stat w_stat;

    dtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl)
    );

    dtb_datapath #(
        .LIMIT_BITS (LIMIT_BITS),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_hour         (i_hour),
        .i_request_len  (i_request_len),
        .i_active_count (i_active_count),
        .i_out_stall    (i_out_stall),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_grant_len    (o_grant_len)
    );

endmodule

@@ sv/dtb_div.sv @@
// ============================================================================
// dtb_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module dtb_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] r_steps;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_diff;
    logic              w_fit;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = w_shift >= {1'b0, r_den};
    assign o_done  = (r_steps == STEP_W'(1));
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_start) begin
            r_steps <= STEP_W'(NUM_W);
        end else if (r_steps != '0) begin
            r_steps <= r_steps - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_steps != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

endmodule

@@ sv/dtb_datapath.sv @@
// ============================================================================
// dtb_datapath
// Configuration, bucket state, request evaluation, divider and result
// register of the throttle.
// ============================================================================
module dtb_datapath #(
    parameter int LIMIT_BITS = 20,
    parameter int CNT_W      = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dtb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [LIMIT_BITS-1:0]           i_cfg_data,
    input  logic [dtb_pkg::CMD_W-1:0]       i_cmd,
    input  logic [dtb_pkg::HOUR_W-1:0]      i_hour,
    input  logic [dtb_pkg::LEN_W-1:0]       i_request_len,
    input  logic [dtb_pkg::CNT_IN_W-1:0]    i_active_count,
    input  logic                            i_out_stall,
    input  dtb_pkg::t_dtb_cmd               i_ctl,
    output dtb_pkg::t_dtb_stat              o_stat,
    output logic                            o_out_valid,
    output logic [dtb_pkg::STAT_W-1:0]      o_status,
    output logic [dtb_pkg::LEN_W-1:0]       o_grant_len
);

    import dtb_pkg::*;

    localparam int TW = LIMIT_BITS + KIB_SHIFT;
    localparam int GW = (TW > LEN_W) ? TW : LEN_W;

    logic                  r_win_en;
    logic [HOUR_W-1:0]     r_win_start;
    logic [HOUR_W-1:0]     r_win_end;
    logic [LIMIT_BITS-1:0] r_down_main;
    logic [LIMIT_BITS-1:0] r_up_main;
    logic [LIMIT_BITS-1:0] r_down_alt;
    logic [LIMIT_BITS-1:0] r_up_alt;

    logic [TW-1:0]         r_down_tok;
    logic [TW-1:0]         r_up_tok;
    logic                  r_active;

    logic [CMD_W-1:0]      r_cmd;
    logic [HOUR_W-1:0]     r_hour;
    logic [LEN_W-1:0]      r_len;
    logic [CNT_W-1:0]      r_count;

    t_dtb_path             r_path;
    t_dtb_path             n_path;
    logic [LIMIT_BITS-1:0] r_dlim;
    logic [LIMIT_BITS-1:0] r_ulim;
    logic [LEN_W-1:0]      r_m1;
    logic [LEN_W-1:0]      r_grant;

    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_status;
    logic [LEN_W-1:0]      r_grant_len;

    logic                  w_in_win;
    logic [LIMIT_BITS-1:0] w_dsel;
    logic [LIMIT_BITS-1:0] w_usel;
    logic [LIMIT_BITS-1:0] w_lim;
    logic [TW-1:0]         w_bucket;
    logic [GW-1:0]         w_m1;
    logic [GW-1:0]         w_min;
    logic [GW-1:0]         w_cons_diff;
    logic [GW-1:0]         w_up_diff;
    logic [TW-1:0]         w_quo;
    logic                  w_div_done;

    always_comb begin
        w_in_win = 1'b0;
        if (r_win_en) begin
            if (r_win_start < r_win_end) begin
                w_in_win = (r_hour >= r_win_start) && (r_hour < r_win_end);
            end else if (r_win_start > r_win_end) begin
                w_in_win = (r_hour >= r_win_start) || (r_hour < r_win_end);
            end
        end
    end

    assign w_dsel   = w_in_win ? r_down_alt : r_down_main;
    assign w_usel   = w_in_win ? r_up_alt : r_up_main;
    assign w_lim    = (r_cmd == CMD_UREQ) ? w_usel : w_dsel;
    assign w_bucket = (r_cmd == CMD_UREQ) ? r_up_tok : r_down_tok;
    assign w_m1     = (GW'(r_len) < GW'(w_bucket)) ? GW'(r_len) : GW'(w_bucket);

    always_comb begin
        n_path = P_PASS;
        unique case (r_cmd) inside
            CMD_TICK:  n_path = P_TICK;
            CMD_DCONS: n_path = P_CONS;
            CMD_DREQ, CMD_UREQ: begin
                if (!r_active || (w_lim == '0) || (r_count == '0)) begin
                    n_path = P_PASS;
                end else if (w_bucket == '0) begin
                    n_path = P_WAIT;
                end else begin
                    n_path = P_GRANT;
                end
            end
            default: n_path = P_PASS;
        endcase
    end

    dtb_div #(
        .NUM_W (TW),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   ({w_lim, {KIB_SHIFT{1'b0}}}),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_min       = (GW'(w_quo) < GW'(r_m1)) ? GW'(w_quo) : GW'(r_m1);
    assign w_cons_diff = GW'(r_down_tok) - GW'(r_len);
    assign w_up_diff   = GW'(r_up_tok) - GW'(r_grant);

    assign o_stat.need_div = (n_path == P_GRANT);
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_en    <= 1'b0;
            r_win_start <= '0;
            r_win_end   <= '0;
            r_down_main <= '0;
            r_up_main   <= '0;
            r_down_alt  <= '0;
            r_up_alt    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN_EN:    r_win_en    <= i_cfg_data[0];
                CFG_WIN_START: r_win_start <= i_cfg_data[HOUR_W-1:0];
                CFG_WIN_END:   r_win_end   <= i_cfg_data[HOUR_W-1:0];
                CFG_DOWN_MAIN: r_down_main <= i_cfg_data;
                CFG_UP_MAIN:   r_up_main   <= i_cfg_data;
                CFG_DOWN_ALT:  r_down_alt  <= i_cfg_data;
                CFG_UP_ALT:    r_up_alt    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_hour  <= i_hour;
            r_len   <= i_request_len;
            r_count <= i_active_count[CNT_W-1:0];
        end
        if (i_ctl.eval) begin
            r_path <= n_path;
            r_dlim <= w_dsel;
            r_ulim <= w_usel;
            r_m1   <= w_m1[LEN_W-1:0];
        end
        if (i_ctl.grant) begin
            r_grant <= w_min[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_tok <= '0;
            r_up_tok   <= '0;
            r_active   <= 1'b0;
        end else if (i_ctl.write) begin
            unique case (r_path)
                P_TICK: begin
                    r_active   <= 1'b1;
                    r_down_tok <= {r_dlim, {KIB_SHIFT{1'b0}}};
                    r_up_tok   <= {r_ulim, {KIB_SHIFT{1'b0}}};
                end
                P_CONS: begin
                    r_down_tok <= (GW'(r_len) >= GW'(r_down_tok)) ? '0
                                                                  : w_cons_diff[TW-1:0];
                end
                P_GRANT: begin
                    if (r_cmd == CMD_UREQ) begin
                        r_up_tok <= w_up_diff[TW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            unique case (r_path)
                P_PASS: begin
                    r_status    <= ST_PASS;
                    r_grant_len <= r_len;
                end
                P_WAIT: begin
                    r_status    <= ST_WAIT;
                    r_grant_len <= '0;
                end
                P_GRANT: begin
                    r_status    <= ST_GRANT;
                    r_grant_len <= r_grant;
                end
                default: begin
                    r_status    <= ST_DONE;
                    r_grant_len <= '0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_grant_len = r_grant_len;

endmodule

@@ sv/dtb_ctrl.sv @@
// ============================================================================
// dtb_ctrl
// Sequencer of the throttle: accept, evaluate, divide, grant, write back.
// ============================================================================
module dtb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dtb_pkg::t_dtb_stat i_stat,
    output logic               o_in_stall,
    output dtb_pkg::t_dtb_cmd  o_ctl
);

    import dtb_pkg::*;

    t_dtb_state r_state;
    t_dtb_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_ctl.eval = 1'b1;
                if (i_stat.need_div) begin
                    o_ctl.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_GRANT;
                end
            end
            S_GRANT: begin
                o_ctl.grant = 1'b1;
                n_state     = S_WB;
            end
            S_WB: begin
                if (i_stat.out_free) begin
                    o_ctl.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ sv/dtb_checker.sv @@
// ============================================================================
// dtb_checker
// Port-level checks of the throttle, bound to the top level.
// ============================================================================
module dtb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [dtb_pkg::STAT_W-1:0] o_status,
    input logic [dtb_pkg::LEN_W-1:0]  o_grant_len
);

    import dtb_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous one still in work");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_WAIT || o_status == ST_DONE)
        |-> o_grant_len == '0)
        else $error("nonzero length on wait or done result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_grant_len))
        else $error("result changed while stalled");

endmodule

bind dual_token_bucket_throttle dtb_checker u_dtb_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the dual token bucket throttle against a cycle-free model of both
// buckets, the hour-window limit selection and the per-transfer grant slice.
// A directed run covers the corner cases. Random runs then follow under
// several register settings, the first four with sender and receiver idling at random.
// ============================================================================
module testbench;
    import dtb_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int LIM_W          = 20;
    localparam int CNT_W          = 10;
    localparam int BKT_W          = 30;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int PHASES         = 6;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  grant_len;
    } t_result;

    class bucket_scoreboard;
        bit              win_en;
        bit [HOUR_W-1:0] win_start;
        bit [HOUR_W-1:0] win_end;
        bit [LIM_W-1:0]  down_main;
        bit [LIM_W-1:0]  up_main;
        bit [LIM_W-1:0]  down_alt;
        bit [LIM_W-1:0]  up_alt;
        bit [BKT_W-1:0]  down_bucket;
        bit [BKT_W-1:0]  up_bucket;
        bit              throttling;
        t_result         expected_q[$];
        int              errors;

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
            case (idx)
                CFG_WIN_EN:    win_en    = data[0];
                CFG_WIN_START: win_start = data[HOUR_W-1:0];
                CFG_WIN_END:   win_end   = data[HOUR_W-1:0];
                CFG_DOWN_MAIN: down_main = data;
                CFG_UP_MAIN:   up_main   = data;
                CFG_DOWN_ALT:  down_alt  = data;
                CFG_UP_ALT:    up_alt    = data;
                default: ;
            endcase
        endfunction

        function bit in_window(logic [HOUR_W-1:0] hour);
            if (!win_en)
                return 1'b0;
            if (win_start < win_end)
                return (hour >= win_start) && (hour < win_end);
            if (win_start > win_end)
                return (hour >= win_start) || (hour < win_end);
            return 1'b0;
        endfunction

        function t_result serve(logic [LIM_W-1:0] limit, logic [BKT_W-1:0] bucket,
                                logic [LEN_W-1:0] len, logic [CNT_W-1:0] count);
            t_result     r;
            logic [63:0] slice;
            if (!throttling || limit == '0 || count == '0) begin
                r.status    = ST_PASS;
                r.grant_len = len;
            end else if (bucket == '0) begin
                r.status    = ST_WAIT;
                r.grant_len = '0;
            end else begin
                slice = 64'(limit);
                slice = (slice << KIB_SHIFT) / 64'(count);
                if (64'(len) < slice)
                    slice = 64'(len);
                if (64'(bucket) < slice)
                    slice = 64'(bucket);
                r.status    = ST_GRANT;
                r.grant_len = slice[LEN_W-1:0];
            end
            return r;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [HOUR_W-1:0] hour,
                                logic [LEN_W-1:0] len, logic [CNT_W-1:0] count);
            t_result         r;
            bit              alt;
            logic [LIM_W-1:0] down_lim;
            logic [LIM_W-1:0] up_lim;
            alt         = in_window(hour);
            down_lim    = alt ? down_alt : down_main;
            up_lim      = alt ? up_alt : up_main;
            r.status    = ST_DONE;
            r.grant_len = '0;
            case (cmd)
                CMD_TICK: begin
                    throttling  = 1'b1;
                    down_bucket = BKT_W'(down_lim);
                    down_bucket = down_bucket << KIB_SHIFT;
                    up_bucket   = BKT_W'(up_lim);
                    up_bucket   = up_bucket << KIB_SHIFT;
                end
                CMD_DREQ: begin
                    r = serve(down_lim, down_bucket, len, count);
                end
                CMD_DCONS: begin
                    if (len >= LEN_W'(down_bucket))
                        down_bucket = '0;
                    else
                        down_bucket = down_bucket - len[BKT_W-1:0];
                end
                default: begin
                    r = serve(up_lim, up_bucket, len, count);
                    if (r.status == ST_GRANT)
                        up_bucket = up_bucket - r.grant_len[BKT_W-1:0];
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [LEN_W-1:0] grant_len);
            t_result exp;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result: status %0d grant_len %0d", status, grant_len);
                return;
            end
            exp = expected_q.pop_front();
            if (status !== exp.status || grant_len !== exp.grant_len) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("wrong result: status exp %0d got %0d, grant_len exp %0d got %0d",
                             exp.status, status, exp.grant_len, grant_len);
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [LIM_W-1:0]      i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd          = CMD_TICK;
    logic [HOUR_W-1:0]     i_hour         = '0;
    logic [LEN_W-1:0]      i_request_len  = '0;
    logic [CNT_IN_W-1:0]   i_active_count = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [STAT_W-1:0]     o_status;
    logic [LEN_W-1:0]      o_grant_len;

    int unsigned      send_idle_pct  = 9;
    int unsigned      recv_stall_pct = 62;
    int               idle_cycles    = 0;
    bucket_scoreboard sb             = new();

    dual_token_bucket_throttle #(
        .LIMIT_BITS (LIM_W),
        .COUNT_BITS (CNT_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_hour         (i_hour),
        .i_request_len  (i_request_len),
        .i_active_count (i_active_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_grant_len    (o_grant_len)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_status, o_grant_len);
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_cmd, i_hour, i_request_len, i_active_count);
            if (i_cfg_we)
                sb.set_reg(i_cfg_idx, i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dual_token_bucket_throttle: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HOUR_W-1:0] hour,
                             input logic [LEN_W-1:0] len, input logic [CNT_IN_W-1:0] count);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_hour         <= hour;
        i_request_len  <= len;
        i_active_count <= count;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic en, input logic [HOUR_W-1:0] start_hour,
                             input logic [HOUR_W-1:0] end_hour,
                             input logic [LIM_W-1:0] down_main, input logic [LIM_W-1:0] up_main,
                             input logic [LIM_W-1:0] down_alt, input logic [LIM_W-1:0] up_alt);
        write_reg(CFG_WIN_EN, LIM_W'(en));
        write_reg(CFG_WIN_START, LIM_W'(start_hour));
        write_reg(CFG_WIN_END, LIM_W'(end_hour));
        write_reg(CFG_DOWN_MAIN, down_main);
        write_reg(CFG_UP_MAIN, up_main);
        write_reg(CFG_DOWN_ALT, down_alt);
        write_reg(CFG_UP_ALT, up_alt);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure_phase(input int phase);
        logic [HOUR_W-1:0] s;
        logic [HOUR_W-1:0] e;
        case (phase)
            0: configure(1'b1, 5'd23, 5'd0, '1, '1, '1, '1);
            1: configure(1'b0, 5'd0, 5'd0, '0, '0, '0, '0);
            2: begin
                s = HOUR_W'($urandom_range(0, 22));
                e = HOUR_W'($urandom_range(s + 1, 23));
                configure(1'b1, s, e, LIM_W'($urandom_range(1, 64)),
                          LIM_W'($urandom_range(1, 64)), LIM_W'($urandom_range(1, 64)),
                          LIM_W'($urandom_range(1, 64)));
            end
            3: begin
                e = HOUR_W'($urandom_range(0, 22));
                s = HOUR_W'($urandom_range(e + 1, 23));
                configure(1'b1, s, e, LIM_W'($urandom_range(1, 64)),
                          LIM_W'($urandom_range(1, 64)), LIM_W'($urandom_range(1, 64)), '0);
            end
            4: begin
                s = HOUR_W'($urandom_range(0, 23));
                configure(1'b0, s, s, LIM_W'($urandom()), LIM_W'($urandom()),
                          LIM_W'($urandom()), LIM_W'($urandom()));
            end
            default: begin
                s = HOUR_W'($urandom_range(0, 23));
                configure(1'b1, s, s, LIM_W'($urandom_range(1, 64)),
                          LIM_W'($urandom_range(1, 64)), LIM_W'($urandom_range(1, 64)),
                          LIM_W'($urandom_range(1, 64)));
            end
        endcase
    endtask

    task automatic send_random_item();
        logic [CMD_W-1:0]    cmd;
        logic [HOUR_W-1:0]   hour;
        logic [LEN_W-1:0]    len;
        logic [CNT_IN_W-1:0] count;
        int unsigned         r;
        r = $urandom_range(0, 99);
        if (r < 8)
            cmd = CMD_TICK;
        else if (r < 43)
            cmd = CMD_DREQ;
        else if (r < 62)
            cmd = CMD_DCONS;
        else
            cmd = CMD_UREQ;
        hour = HOUR_W'(($urandom_range(0, 99) < 88) ? $urandom_range(0, 23)
                                                    : $urandom_range(24, 31));
        r = $urandom_range(0, 99);
        if (r < 10)
            len = '0;
        else if (r < 20)
            len = '1;
        else if (r < 60)
            len = $urandom_range(0, 70000);
        else if (r < 80)
            len = $urandom_range(0, 2048);
        else
            len = $urandom();
        r = $urandom_range(0, 99);
        if (r < 8)
            count = '0;
        else if (r < 60)
            count = CNT_IN_W'($urandom_range(1, 8));
        else if (r < 90)
            count = CNT_IN_W'($urandom());
        else
            count = '1;
        send_item(cmd, hour, len, count);
    endtask

    task automatic run_directed();
        send_item(CMD_DREQ, 5'd0, 32'hFFFF_FFFF, 10'd1023);
        send_item(CMD_UREQ, 5'd31, 32'd0, 10'd0);
        send_item(CMD_DCONS, 5'd5, 32'd5, 10'd1);
        wait_drained();
        configure(1'b1, 5'd22, 5'd3, 20'd1, 20'hFFFFF, 20'd0, 20'd2);
        send_item(CMD_TICK, 5'd10, 32'd0, 10'd0);
        send_item(CMD_DREQ, 5'd10, 32'd77, 10'd0);
        send_item(CMD_DREQ, 5'd10, 32'hFFFF_FFFF, 10'd1);
        send_item(CMD_DREQ, 5'd10, 32'hFFFF_FFFF, 10'd3);
        send_item(CMD_DREQ, 5'd10, 32'd0, 10'd1);
        send_item(CMD_DCONS, 5'd10, 32'd100, 10'd0);
        send_item(CMD_DREQ, 5'd10, 32'd2000, 10'd1);
        send_item(CMD_DCONS, 5'd10, 32'hFFFF_FFFF, 10'd0);
        send_item(CMD_DREQ, 5'd10, 32'd500, 10'd1);
        send_item(CMD_UREQ, 5'd10, 32'hFFFF_FFFF, 10'd1023);
        send_item(CMD_UREQ, 5'd10, 32'hFFFF_FFFF, 10'd1);
        send_item(CMD_UREQ, 5'd10, 32'd5, 10'd1);
        send_item(CMD_TICK, 5'd23, 32'd0, 10'd0);
        send_item(CMD_DREQ, 5'd23, 32'd1234, 10'd5);
        send_item(CMD_UREQ, 5'd23, 32'd3000, 10'd1);
        send_item(CMD_TICK, 5'd3, 32'hFFFF_FFFF, 10'd1023);
        send_item(CMD_TICK, 5'd2, 32'd0, 10'd0);
        send_item(CMD_TICK, 5'd31, 32'd0, 10'd0);
        send_item(CMD_UREQ, 5'd31, 32'd4000, 10'd2);
        send_item(CMD_TICK, 5'd22, 32'd0, 10'd0);
        send_item(CMD_TICK, 5'd21, 32'd0, 10'd0);
        send_item(CMD_UREQ, 5'd21, 32'hFFFF_FFFF, 10'd1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p / 2)
                0: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 62;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 9;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            configure_phase(p);
            send_item(CMD_TICK, HOUR_W'($urandom_range(0, 23)), $urandom(),
                      CNT_IN_W'($urandom()));
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (n == RANDOM_ITEMS / 2)
                    wait_drained();
                send_random_item();
            end
        end
        wait_drained();
        repeat (LIM_W + 20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("dual_token_bucket_throttle: match");
        else
            $display("dual_token_bucket_throttle: mismatch");
        $finish;
    end

endmodule
